// File: hdl/wera_pkg.sv
// ---------------------------------------------------------------------------
// wera_pkg
// Shared types and constants of the windowed event rate alarm.
// ---------------------------------------------------------------------------
package wera_pkg;

	localparam int CMD_W   = 2;
	localparam int PROC_W  = 15;
	localparam int AGENT_W = 10;
	localparam int TIME_W  = 64;
	localparam int WIN_W   = 40;
	localparam int LIM_W   = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 40;

	// event kinds, also used as alert kinds
	localparam logic [CMD_W-1:0] CMD_SYSCALL = 2'd0;
	localparam logic [CMD_W-1:0] CMD_EXECVE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CONNECT = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYSCALL_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EXECVE_LIMIT  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CONNECT_LIMIT = 2'd3;

	localparam logic [WIN_W-1:0] WINDOW_LEN_RST    = 40'd1000000000;
	localparam logic [LIM_W-1:0] SYSCALL_LIMIT_RST = 32'd10000;
	localparam logic [LIM_W-1:0] EXECVE_LIMIT_RST  = 32'd50;
	localparam logic [LIM_W-1:0] CONNECT_LIMIT_RST = 32'd100;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_UPDATE
	} state_t;

endpackage

// File: hdl/wera_evt_if.sv
// ---------------------------------------------------------------------------
// wera_evt_if
// Event channel: one transfer carries one kernel event.
// ---------------------------------------------------------------------------
interface wera_evt_if import wera_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   cmd;
	logic [PROC_W-1:0]  proc_id;
	logic [AGENT_W-1:0] agent_num;
	logic [TIME_W-1:0]  now_ns;

	modport source (output valid, cmd, proc_id, agent_num, now_ns, input ready);
	modport sink   (input valid, cmd, proc_id, agent_num, now_ns, output ready);
endinterface

// File: hdl/wera_alert_if.sv
// ---------------------------------------------------------------------------
// wera_alert_if
// Alert channel: one transfer carries one rate alert.
// ---------------------------------------------------------------------------
interface wera_alert_if import wera_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [TIME_W-1:0]  alert_time_ns;
	logic [PROC_W-1:0]  alert_proc;
	logic [AGENT_W-1:0] alert_agent;
	logic [CMD_W-1:0]   alert_kind;
	logic [LIM_W-1:0]   alert_count;

	modport source (output valid, alert_time_ns, alert_proc, alert_agent, alert_kind,
		alert_count, input ready);
	modport sink   (input valid, alert_time_ns, alert_proc, alert_agent, alert_kind,
		alert_count, output ready);
endinterface

// File: hdl/wera_cfg_if.sv
// ---------------------------------------------------------------------------
// wera_cfg_if
// Register write channel: index and data, one register per transfer.
// ---------------------------------------------------------------------------
interface wera_cfg_if import wera_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/windowed_event_rate_alarm.sv
// ---------------------------------------------------------------------------
// windowed_event_rate_alarm
// Fixed-window event counters per process and per agent with limit alerts.
// ---------------------------------------------------------------------------
// Syscall events count per process slot, execve and connect events per agent
// slot (agent 0 is dropped, as is an unknown kind). Counter state sits in two
// RAMs: a process RAM of PROC_SLOTS words and an agent RAM of 2*AGENT_SLOTS
// words (execve half and connect half), each word holding valid, count and
// window start. A counted event goes through RAM read at the transfer, window
// check, then count update and write-back; a dropped event leaves the FSM idle.
// The update cycle waits while an earlier alert is still held in the output
// register. After reset a clearing pass over max(PROC_SLOTS, 2*AGENT_SLOTS)
// words resets the valid bits; no event is taken during it, register writes
// are. PROC_SLOTS and AGENT_SLOTS must be powers of two; this is not checked.
module windowed_event_rate_alarm import wera_pkg::*; #(
	parameter int PROC_SLOTS  = 32768,
	parameter int AGENT_SLOTS = 1024,
	parameter int COUNT_BITS  = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	wera_evt_if.sink       evt,
	wera_alert_if.source   alert,
	wera_cfg_if.sink       cfg
);

	localparam int PROC_AW   = $clog2(PROC_SLOTS);
	localparam int AGT_AW    = $clog2(AGENT_SLOTS);
	localparam int AGT_DEPTH = 2 * AGENT_SLOTS;
	localparam int CLR_DEPTH = (PROC_SLOTS > AGT_DEPTH) ? PROC_SLOTS : AGT_DEPTH;
	localparam int CLR_AW    = $clog2(CLR_DEPTH);
	localparam int WORD_W    = 1 + COUNT_BITS + TIME_W;
	localparam int CMP_W     = (COUNT_BITS > LIM_W) ? COUNT_BITS : LIM_W;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	// configuration registers
	logic [WIN_W-1:0] win_len_q;
	logic [LIM_W-1:0] sys_lim_q;
	logic [LIM_W-1:0] exe_lim_q;
	logic [LIM_W-1:0] con_lim_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len_q <= WINDOW_LEN_RST;
			sys_lim_q <= SYSCALL_LIMIT_RST;
			exe_lim_q <= EXECVE_LIMIT_RST;
			con_lim_q <= CONNECT_LIMIT_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_WINDOW_LEN:    win_len_q <= cfg.data[WIN_W-1:0];
				REG_SYSCALL_LIMIT: sys_lim_q <= cfg.data[LIM_W-1:0];
				REG_EXECVE_LIMIT:  exe_lim_q <= cfg.data[LIM_W-1:0];
				REG_CONNECT_LIMIT: con_lim_q <= cfg.data[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	// state and item registers
	state_t state_q, state_d;
	logic [CLR_AW-1:0]  clr_q;
	logic [CMD_W-1:0]   cmd_q;
	logic [PROC_W-1:0]  proc_q;
	logic [AGENT_W-1:0] agent_q;
	logic [TIME_W-1:0]  now_q;
	logic               use_proc_q;

	// check-stage registers
	logic                  rd_valid_q;
	logic [COUNT_BITS-1:0] rd_count_q;
	logic [TIME_W-1:0]     rd_start_q;
	logic                  expired_q;

	// output register
	logic               out_valid_q;
	logic [TIME_W-1:0]  out_time_q;
	logic [PROC_W-1:0]  out_proc_q;
	logic [AGENT_W-1:0] out_agent_q;
	logic [CMD_W-1:0]   out_kind_q;
	logic [LIM_W-1:0]   out_count_q;

	// RAM ports
	logic               pm_we, pm_re, am_we, am_re;
	logic [PROC_AW-1:0] pm_waddr, pm_raddr;
	logic [AGT_AW:0]    am_waddr, am_raddr;
	logic [WORD_W-1:0]  wr_word, pm_rdata, am_rdata, rd_word;

	// accept decode
	logic evt_xfer, cnt_proc, cnt_agent, clr_done, out_free, proceed;
	logic [CLR_AW:0] clr_ext;

	assign evt_xfer  = evt.valid && evt.ready;
	assign cnt_proc  = (evt.cmd == CMD_SYSCALL);
	assign cnt_agent = (evt.cmd inside {CMD_EXECVE, CMD_CONNECT}) && (evt.agent_num != '0);
	assign clr_done  = (clr_q == CLR_AW'(CLR_DEPTH - 1));
	assign clr_ext   = {1'b0, clr_q};
	assign out_free  = !out_valid_q || alert.ready;

	// update stage arithmetic
	logic                  restart, hit;
	logic [COUNT_BITS-1:0] base_count, new_count;
	logic [LIM_W-1:0]      limit_sel;
	logic [TIME_W-1:0]     new_start;

	always_comb begin
		case (cmd_q)
			CMD_SYSCALL: limit_sel = sys_lim_q;
			CMD_EXECVE:  limit_sel = exe_lim_q;
			CMD_CONNECT: limit_sel = con_lim_q;
			default:     limit_sel = sys_lim_q;
		endcase
		restart    = !rd_valid_q || expired_q;
		base_count = restart ? '0 : rd_count_q;
		new_count  = (base_count == COUNT_MAX) ? base_count : base_count + 1'b1;
		new_start  = restart ? now_q : rd_start_q;
		// the first event of a key never alerts
		hit        = rd_valid_q && (CMP_W'(new_count) == CMP_W'(limit_sel));
	end

	assign proceed = !hit || out_free;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:  if (clr_done) state_d = ST_IDLE;
			ST_IDLE:   if (evt_xfer && (cnt_proc || cnt_agent)) state_d = ST_CHECK;
			ST_CHECK:  state_d = ST_UPDATE;
			ST_UPDATE: if (proceed) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// FSM outputs: handshake and RAM control
	always_comb begin
		evt.ready = 1'b0;
		pm_we     = 1'b0;
		am_we     = 1'b0;
		pm_re     = 1'b0;
		am_re     = 1'b0;
		pm_waddr  = PROC_AW'(proc_q);
		am_waddr  = {(cmd_q == CMD_CONNECT), AGT_AW'(agent_q)};
		wr_word   = {1'b1, new_count, new_start};
		case (state_q)
			ST_CLEAR: begin
				pm_we    = (clr_ext < (CLR_AW + 1)'(PROC_SLOTS));
				am_we    = (clr_ext < (CLR_AW + 1)'(AGT_DEPTH));
				pm_waddr = PROC_AW'(clr_q);
				am_waddr = (AGT_AW + 1)'(clr_q);
				wr_word  = '0;
			end
			ST_IDLE: begin
				evt.ready = 1'b1;
				pm_re     = evt.valid && cnt_proc;
				am_re     = evt.valid && cnt_agent;
			end
			ST_CHECK: ;
			ST_UPDATE: begin
				pm_we = proceed && use_proc_q;
				am_we = proceed && !use_proc_q;
			end
			default: ;
		endcase
	end

	assign pm_raddr = PROC_AW'(evt.proc_id);
	assign am_raddr = {(evt.cmd == CMD_CONNECT), AGT_AW'(evt.agent_num)};

	wera_ram #(.WIDTH(WORD_W), .DEPTH(PROC_SLOTS)) u_proc_ram (
		.clk   (clk),
		.we    (pm_we),
		.waddr (pm_waddr),
		.wdata (wr_word),
		.re    (pm_re),
		.raddr (pm_raddr),
		.rdata (pm_rdata)
	);

	wera_ram #(.WIDTH(WORD_W), .DEPTH(AGT_DEPTH)) u_agent_ram (
		.clk   (clk),
		.we    (am_we),
		.waddr (am_waddr),
		.wdata (wr_word),
		.re    (am_re),
		.raddr (am_raddr),
		.rdata (am_rdata)
	);

	assign rd_word = use_proc_q ? pm_rdata : am_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR && !clr_done) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == ST_UPDATE && hit && out_free) begin
				out_valid_q <= 1'b1;
			end else if (alert.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (evt_xfer) begin
			cmd_q      <= evt.cmd;
			proc_q     <= evt.proc_id;
			agent_q    <= evt.agent_num;
			now_q      <= evt.now_ns;
			use_proc_q <= cnt_proc;
		end
		if (state_q == ST_CHECK) begin
			rd_valid_q <= rd_word[WORD_W-1];
			rd_count_q <= rd_word[TIME_W +: COUNT_BITS];
			rd_start_q <= rd_word[TIME_W-1:0];
			// elapsed time wraps modulo 2^64
			expired_q  <= (now_q - rd_word[TIME_W-1:0]) >= TIME_W'(win_len_q);
		end
		if (state_q == ST_UPDATE && hit && out_free) begin
			out_time_q  <= now_q;
			out_proc_q  <= proc_q;
			out_agent_q <= agent_q;
			out_kind_q  <= cmd_q;
			out_count_q <= LIM_W'(new_count);
		end
	end

	assign alert.valid         = out_valid_q;
	assign alert.alert_time_ns = out_time_q;
	assign alert.alert_proc    = out_proc_q;
	assign alert.alert_agent   = out_agent_q;
	assign alert.alert_kind    = out_kind_q;
	assign alert.alert_count   = out_count_q;

	// a counted event always goes on to the window check
	a_counted_to_check: assert property (@(posedge clk) disable iff (!arst_n)
		(evt_xfer && (cnt_proc || cnt_agent)) |=> (state_q == ST_CHECK))
		else $error("counted event did not enter window check");

	// alerts come only from the update stage
	a_alert_from_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_UPDATE))
		else $error("alert raised outside update stage");

	// no RAM write while a read-modify-write is between read and update
	a_no_write_early: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_CHECK) |-> !(pm_we || am_we))
		else $error("counter RAM written outside update or clear");

	// a pending alert is never overwritten by the next one
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !alert.ready && state_q == ST_UPDATE && hit) |=>
		(state_q == ST_UPDATE && $stable(out_time_q)))
		else $error("pending alert overwritten");

endmodule

// File: hdl/wera_ram.sv
// ---------------------------------------------------------------------------
// wera_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ---------------------------------------------------------------------------
module wera_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: tb/windowed_event_rate_alarm_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// windowed_event_rate_alarm_tb
// Self-checking bench for the fixed-window event rate alarm. Directed cases
// cover first events, window restarts, timestamp wrap, dropped events and
// the register extremes. Random traffic on small key pools then drives
// limits to be hit, under three sender/receiver idling schemes. Every alert
// is checked field by field against an in-bench rate counter model.
// ---------------------------------------------------------------------------
module windowed_event_rate_alarm_tb import wera_pkg::*; ();

	localparam int PROC_SLOTS   = 32768;
	localparam int AGENT_SLOTS  = 1024;
	localparam int COUNT_BITS   = 32;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int PHASE_ITEMS  = 567;

	localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [TIME_W-1:0]     stamp_t;
	typedef logic [LIM_W-1:0]      lim_t;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [PROC_W-1:0]  proc_id;
		logic [AGENT_W-1:0] agent_num;
		stamp_t             now_ns;
	} evt_t;

	typedef struct packed {
		stamp_t             alert_time_ns;
		logic [PROC_W-1:0]  alert_proc;
		logic [AGENT_W-1:0] alert_agent;
		logic [CMD_W-1:0]   alert_kind;
		lim_t               alert_count;
	} alert_t;

	logic clk;
	logic arst_n;

	wera_evt_if   evt_ch ();
	wera_alert_if alert_ch ();
	wera_cfg_if   cfg_ch ();

	windowed_event_rate_alarm #(
		.PROC_SLOTS  (PROC_SLOTS),
		.AGENT_SLOTS (AGENT_SLOTS),
		.COUNT_BITS  (COUNT_BITS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt_ch),
		.alert  (alert_ch),
		.cfg    (cfg_ch)
	);

	// rate counter model state
	bit     proc_vld   [PROC_SLOTS];
	count_t proc_cnt   [PROC_SLOTS];
	stamp_t proc_start [PROC_SLOTS];
	bit     exec_vld   [AGENT_SLOTS];
	count_t exec_cnt   [AGENT_SLOTS];
	stamp_t exec_start [AGENT_SLOTS];
	bit     conn_vld   [AGENT_SLOTS];
	count_t conn_cnt   [AGENT_SLOTS];
	stamp_t conn_start [AGENT_SLOTS];

	logic [WIN_W-1:0] win_len_cfg = WINDOW_LEN_RST;
	lim_t             sys_lim     = SYSCALL_LIMIT_RST;
	lim_t             exe_lim     = EXECVE_LIMIT_RST;
	lim_t             con_lim     = CONNECT_LIMIT_RST;

	alert_t      pending_alerts [$];
	int          err_cnt;
	int          src_idle_pct;
	int          snk_stall_pct;
	int unsigned cycle_cnt;
	stamp_t      evt_clock;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("windowed_event_rate_alarm test failed");
		$finish;
	end

	function automatic bit bump_counter(inout bit vld, inout count_t cnt, inout stamp_t start,
		input stamp_t now, input lim_t limit, output count_t seen);
		seen = '0;
		if (!vld) begin
			// new key: open window, never alerts
			vld = 1'b1;
			cnt = 1;
			start = now;
			return 1'b0;
		end
		if ((now - start) >= stamp_t'(win_len_cfg)) begin
			cnt = '0;
			start = now;
		end
		if (cnt != '1)
			cnt = cnt + 1'b1;
		seen = cnt;
		return cnt == limit;
	endfunction

	function automatic bit predict_alert(input evt_t e, output alert_t a);
		bit     hit;
		count_t seen;
		hit = 1'b0;
		seen = '0;
		case (e.cmd)
			CMD_SYSCALL: begin
				hit = bump_counter(proc_vld[e.proc_id], proc_cnt[e.proc_id],
					proc_start[e.proc_id], e.now_ns, sys_lim, seen);
			end
			CMD_EXECVE: begin
				if (e.agent_num != '0)
					hit = bump_counter(exec_vld[e.agent_num], exec_cnt[e.agent_num],
						exec_start[e.agent_num], e.now_ns, exe_lim, seen);
			end
			CMD_CONNECT: begin
				if (e.agent_num != '0)
					hit = bump_counter(conn_vld[e.agent_num], conn_cnt[e.agent_num],
						conn_start[e.agent_num], e.now_ns, con_lim, seen);
			end
			default: ;
		endcase
		a.alert_time_ns = e.now_ns;
		a.alert_proc    = e.proc_id;
		a.alert_agent   = e.agent_num;
		a.alert_kind    = e.cmd;
		a.alert_count   = seen[LIM_W-1:0];
		return hit;
	endfunction

	function automatic evt_t mk_evt(input logic [CMD_W-1:0] cmd, input int unsigned pid,
		input int unsigned agent, input stamp_t now);
		evt_t e;
		e.cmd       = cmd;
		e.proc_id   = pid[PROC_W-1:0];
		e.agent_num = agent[AGENT_W-1:0];
		e.now_ns    = now;
		return e;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("%0t ns: alert mismatch on %s: got 0x%0h, expected 0x%0h",
			$time, what, got, want);
		err_cnt++;
	endtask

	// result checker and receiver backpressure
	always @(posedge clk) begin
		alert_t want;
		if (alert_ch.valid === 1'b1 && alert_ch.ready === 1'b1) begin
			if (pending_alerts.size() == 0) begin
				report_mismatch("unexpected alert time", alert_ch.alert_time_ns, '0);
			end else begin
				want = pending_alerts.pop_front();
				if (alert_ch.alert_time_ns !== want.alert_time_ns)
					report_mismatch("alert_time_ns", alert_ch.alert_time_ns, want.alert_time_ns);
				if (alert_ch.alert_proc !== want.alert_proc)
					report_mismatch("alert_proc", alert_ch.alert_proc, want.alert_proc);
				if (alert_ch.alert_agent !== want.alert_agent)
					report_mismatch("alert_agent", alert_ch.alert_agent, want.alert_agent);
				if (alert_ch.alert_kind !== want.alert_kind)
					report_mismatch("alert_kind", alert_ch.alert_kind, want.alert_kind);
				if (alert_ch.alert_count !== want.alert_count)
					report_mismatch("alert_count", alert_ch.alert_count, want.alert_count);
			end
		end
		alert_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
	end

	// valid stays high after the transfer; the next call or a drain moves it
	task automatic send_event(input evt_t e);
		alert_t a;
		if ($urandom_range(99) < src_idle_pct) begin
			evt_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		evt_ch.valid     <= 1'b1;
		evt_ch.cmd       <= e.cmd;
		evt_ch.proc_id   <= e.proc_id;
		evt_ch.agent_num <= e.agent_num;
		evt_ch.now_ns    <= e.now_ns;
		@(posedge clk);
		while (evt_ch.ready !== 1'b1) @(posedge clk);
		if (predict_alert(e, a))
			pending_alerts.push_back(a);
	endtask

	task automatic drain_alerts();
		evt_ch.valid <= 1'b0;
		while (pending_alerts.size() != 0) @(posedge clk);
		// dropped or alert-free events may still be in the pipe
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		@(posedge clk);
		while (cfg_ch.ready !== 1'b1) @(posedge clk);
		case (idx)
			REG_WINDOW_LEN:    win_len_cfg = data[WIN_W-1:0];
			REG_SYSCALL_LIMIT: sys_lim = data[LIM_W-1:0];
			REG_EXECVE_LIMIT:  exe_lim = data[LIM_W-1:0];
			REG_CONNECT_LIMIT: con_lim = data[LIM_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_config(input logic [CFG_DATA_W-1:0] win, input logic [CFG_DATA_W-1:0] sys,
		input logic [CFG_DATA_W-1:0] exe, input logic [CFG_DATA_W-1:0] con);
		write_reg(REG_WINDOW_LEN, win);
		write_reg(REG_SYSCALL_LIMIT, sys);
		write_reg(REG_EXECVE_LIMIT, exe);
		write_reg(REG_CONNECT_LIMIT, con);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic random_config();
		logic [CFG_DATA_W-1:0] win;
		win = ($urandom_range(7) == 0) ? '0 : CFG_DATA_W'($urandom_range(20, 400));
		// limits ignore the upper data bits
		apply_config(win,
			{8'($urandom), 32'($urandom_range(1, 6))},
			{8'($urandom), 32'($urandom_range(1, 6))},
			{8'($urandom), 32'($urandom_range(1, 6))});
	endtask

	task automatic test_first_event_and_limits();
		drain_alerts();
		apply_config(40'd100, 40'd2, 40'd1, 40'd2);
		send_event(mk_evt(CMD_SYSCALL, 0, 0, 64'd0));
		send_event(mk_evt(CMD_SYSCALL, 0, 0, 64'd10));
		send_event(mk_evt(CMD_SYSCALL, 32'h7FFF, 32'h3FF, 64'd20));
		// limit 1 is not hit by the creating event
		send_event(mk_evt(CMD_EXECVE, 32'h7FFF, 32'h3FF, 64'd20));
		send_event(mk_evt(CMD_EXECVE, 32'h7FFF, 32'h3FF, 64'd30));
		send_event(mk_evt(CMD_EXECVE, 32'h7FFF, 32'h3FF, 64'd200));
	endtask

	task automatic test_ignored_events();
		send_event(mk_evt(CMD_EXECVE, 3, 0, 64'd210));
		send_event(mk_evt(CMD_CONNECT, 3, 0, 64'd211));
		send_event(mk_evt(CMD_UNKNOWN, 0, 1, 64'd212));
		send_event(mk_evt(CMD_UNKNOWN, 32'h7FFF, 32'h3FF, 64'hFFFF_FFFF_FFFF_FFFF));
		send_event(mk_evt(CMD_SYSCALL, 32'h7FFF, 32'h3FF, 64'd213));
	endtask

	task automatic test_window_boundary();
		send_event(mk_evt(CMD_CONNECT, 9, 1, 64'd300));
		send_event(mk_evt(CMD_CONNECT, 9, 1, 64'd399));
		send_event(mk_evt(CMD_CONNECT, 9, 1, 64'd400));
		send_event(mk_evt(CMD_SYSCALL, 0, 0, 64'd400));
		send_event(mk_evt(CMD_SYSCALL, 0, 0, 64'd499));
		// elapsed time wraps through zero
		send_event(mk_evt(CMD_SYSCALL, 5, 7, 64'hFFFF_FFFF_FFFF_FFF6));
		send_event(mk_evt(CMD_SYSCALL, 5, 7, 64'd5));
		send_event(mk_evt(CMD_SYSCALL, 5, 7, 64'hFFFF_FFFF_FFFF_FFFF));
	endtask

	task automatic test_zero_window_and_limit();
		drain_alerts();
		apply_config(40'd0, 40'd0, 40'd0, 40'd0);
		send_event(mk_evt(CMD_SYSCALL, 0, 0, 64'd600));
		send_event(mk_evt(CMD_SYSCALL, 0, 0, 64'd600));
		send_event(mk_evt(CMD_CONNECT, 9, 1, 64'd601));
		send_event(mk_evt(CMD_EXECVE, 9, 32'h3FF, 64'd601));
	endtask

	task automatic test_max_settings();
		drain_alerts();
		apply_config(40'hFF_FFFF_FFFF, 40'hFF_0000_0001, 40'h00_FFFF_FFFF, 40'hAA_0000_0001);
		send_event(mk_evt(CMD_SYSCALL, 0, 0, 64'd700));
		send_event(mk_evt(CMD_CONNECT, 9, 1, 64'h8000_0000_0000_0000));
		send_event(mk_evt(CMD_EXECVE, 9, 32'h3FF, 64'h8000_0000_0000_0001));
	endtask

	task automatic test_random_traffic(input int src_pct, input int snk_pct, input int n_items,
		input stamp_t base);
		logic [PROC_W-1:0]  pid_pool [6];
		logic [AGENT_W-1:0] agent_pool [4];
		evt_t e;
		int   counted;
		int   roll;
		bit   mid_done;
		counted = 0;
		mid_done = 1'b0;
		drain_alerts();
		src_idle_pct = src_pct;
		snk_stall_pct = snk_pct;
		random_config();
		evt_clock = base;
		foreach (pid_pool[i]) pid_pool[i] = PROC_W'($urandom);
		foreach (agent_pool[i]) agent_pool[i] = AGENT_W'($urandom_range(1, AGENT_SLOTS - 1));
		while (counted < n_items) begin
			if (!mid_done && counted >= n_items / 2) begin
				// hold the sender until every alert is out, then retune
				drain_alerts();
				random_config();
				mid_done = 1'b1;
			end
			evt_clock += ($urandom_range(99) < 5) ? $urandom_range(0, 1000) : $urandom_range(0, 6);
			e.now_ns = evt_clock;
			roll = $urandom_range(99);
			if (roll < 85) begin
				e.cmd       = CMD_W'($urandom_range(CMD_SYSCALL, CMD_CONNECT));
				e.proc_id   = pid_pool[$urandom_range(0, 5)];
				e.agent_num = (e.cmd == CMD_SYSCALL) ? AGENT_W'($urandom)
					: agent_pool[$urandom_range(0, 3)];
			end else if (roll < 90) begin
				e.cmd       = CMD_W'($urandom_range(CMD_SYSCALL, CMD_CONNECT));
				e.proc_id   = PROC_W'($urandom);
				e.agent_num = AGENT_W'($urandom_range(1, AGENT_SLOTS - 1));
			end else if (roll < 95) begin
				e.cmd       = CMD_UNKNOWN;
				e.proc_id   = PROC_W'($urandom);
				e.agent_num = AGENT_W'($urandom);
			end else begin
				e.cmd       = ($urandom_range(1) == 0) ? CMD_EXECVE : CMD_CONNECT;
				e.proc_id   = pid_pool[$urandom_range(0, 5)];
				e.agent_num = '0;
			end
			send_event(e);
			counted++;
		end
	endtask

	initial begin
		arst_n           <= 1'b0;
		evt_ch.valid     <= 1'b0;
		evt_ch.cmd       <= CMD_SYSCALL;
		evt_ch.proc_id   <= '0;
		evt_ch.agent_num <= '0;
		evt_ch.now_ns    <= '0;
		cfg_ch.valid     <= 1'b0;
		cfg_ch.index     <= REG_WINDOW_LEN;
		cfg_ch.data      <= '0;
		src_idle_pct  = 14;
		snk_stall_pct = 74;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		test_first_event_and_limits();
		test_ignored_events();
		test_window_boundary();
		test_zero_window_and_limit();
		test_max_settings();
		test_random_traffic(14, 74, PHASE_ITEMS, {$urandom, $urandom});
		test_random_traffic(74, 14, PHASE_ITEMS, {$urandom, $urandom});
		test_random_traffic(0, 0, PHASE_ITEMS, 64'hFFFF_FFFF_FFFF_F000);
		drain_alerts();

		if (err_cnt == 0)
			$display("windowed_event_rate_alarm test passed");
		else
			$display("windowed_event_rate_alarm test failed");
		$finish;
	end

endmodule
